// ===== src/vn_pkg.sv =====
// vn_pkg: shared types for the vector normalize pipeline.
// No dependencies.
package vn_pkg;

  // Control word handed from cell to cell alongside the datapath.
  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] neg;
  } vn_ctl_t;

  localparam int unsigned NUM_LANES = 3;

endpackage

// ===== src/vn_sqrt_cell.sv =====
// vn_sqrt_cell: one restoring square-root digit step, registered.
// Depends on vn_pkg.
module vn_sqrt_cell #(
  parameter int unsigned CW = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  vn_pkg::vn_ctl_t            ctl_i,
  input  logic [2*CW-1:0]            rad_i,
  input  logic [CW+1:0]              rem_i,
  input  logic [CW-1:0]              root_i,
  input  logic [3*CW-1:0]            abs_i,
  output vn_pkg::vn_ctl_t            ctl_o,
  output logic [2*CW-1:0]            rad_o,
  output logic [CW+1:0]              rem_o,
  output logic [CW-1:0]              root_o,
  output logic [3*CW-1:0]            abs_o
);
  import vn_pkg::*;

  logic [CW+3:0] rem_sh;
  logic [CW+3:0] trial;
  logic [CW+3:0] diff;
  logic          ge;
  vn_ctl_t       ctl_r;
  logic [2*CW-1:0] rad_r;
  logic [CW+1:0] rem_r, rem_nxt;
  logic [CW-1:0] root_r, root_nxt;
  logic [3*CW-1:0] abs_r;

  always_comb begin
    rem_sh   = {rem_i, rad_i[2*CW-1 -: 2]};
    trial    = {2'b00, root_i, 2'b01};
    diff     = rem_sh - trial;
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? diff[CW+1:0] : rem_sh[CW+1:0];
    root_nxt = {root_i[CW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
    rad_r  <= {rad_i[2*CW-3:0], 2'b00};
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    abs_r  <= abs_i;
  end

  assign ctl_o  = ctl_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign abs_o  = abs_r;
endmodule

// ===== src/vn_div_cell.sv =====
// vn_div_cell: one restoring divide step for all three lanes, registered.
// Depends on vn_pkg.
module vn_div_cell #(
  parameter int unsigned CW = 16,
  parameter int unsigned QW = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vn_pkg::vn_ctl_t      ctl_i,
  input  logic [CW-1:0]        mag_i,
  input  logic [2:0]           nb_i,
  input  logic [3*CW-1:0]      rem_i,
  input  logic [3*QW-1:0]      quo_i,
  output vn_pkg::vn_ctl_t      ctl_o,
  output logic [CW-1:0]        mag_o,
  output logic [3*CW-1:0]      rem_o,
  output logic [3*QW-1:0]      quo_o
);
  import vn_pkg::*;

  vn_ctl_t         ctl_r;
  logic [CW-1:0]   mag_r;
  logic [3*CW-1:0] rem_r, rem_nxt;
  logic [3*QW-1:0] quo_r, quo_nxt;

  always_comb begin
    logic [CW:0] r2;
    logic [CW:0] d;
    rem_nxt = '0;
    quo_nxt = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      r2 = {rem_i[l*CW +: CW], nb_i[l]};
      d  = r2 - {1'b0, mag_i};
      if (r2 >= {1'b0, mag_i}) begin
        rem_nxt[l*CW +: CW] = d[CW-1:0];
      end else begin
        rem_nxt[l*CW +: CW] = r2[CW-1:0];
      end
      quo_nxt[l*QW +: QW] = {quo_i[l*QW +: QW-1], (r2 >= {1'b0, mag_i})};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
    mag_r <= mag_i;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign ctl_o = ctl_r;
  assign mag_o = mag_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;
endmodule

// ===== src/vector3_normalize.sv =====
// vector3_normalize: 3D fixed-point vector normalization, fully pipelined.
// Depends on vn_pkg, vn_sqrt_cell, vn_div_cell.
// Pipeline: sign split, squares and sum registers, then one sqrt cell per root bit
//   and one divide cell per quotient bit, then the output register.
// Throughput: one vector per cycle; busy is never raised.
// Reset: synchronous active-low rst_n clears all valid bits; no result is
//   dropped by the receiver since it cannot stall.
module vector3_normalize #(
  parameter int unsigned COMPONENT_WIDTH    = 16,
  parameter int unsigned UNIT_FRACTION_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COMPONENT_WIDTH-1:0]   in_x,
  input  logic signed [COMPONENT_WIDTH-1:0]   in_y,
  input  logic signed [COMPONENT_WIDTH-1:0]   in_z,
  output logic                                out_valid,
  output logic signed [UNIT_FRACTION_BITS+1:0] out_unit_x,
  output logic signed [UNIT_FRACTION_BITS+1:0] out_unit_y,
  output logic signed [UNIT_FRACTION_BITS+1:0] out_unit_z,
  output logic [COMPONENT_WIDTH-1:0]          out_magnitude,
  output logic                                out_zero_vector
);
  import vn_pkg::*;

  localparam int unsigned CW  = COMPONENT_WIDTH;
  localparam int unsigned UF  = UNIT_FRACTION_BITS;
  localparam int unsigned QW  = UF + 1;   // quotient never exceeds 2^UF
  localparam int unsigned UW  = UF + 2;   // signed unit word
  localparam int unsigned LAT = CW + UF + 5;

  // The block never stalls the sender.
  assign busy = 1'b0;

  // ---- Stage 1: sign split and absolute value ----
  vn_ctl_t          s1_ctl_r;
  logic [3*CW-1:0]  s1_abs_r;
  logic [3*CW-1:0]  abs_nxt;
  logic [2:0]       neg_nxt;

  always_comb begin
    neg_nxt = {in_z[CW-1], in_y[CW-1], in_x[CW-1]};
    abs_nxt[0*CW +: CW] = in_x[CW-1] ? (~in_x + 1'b1) : in_x;
    abs_nxt[1*CW +: CW] = in_y[CW-1] ? (~in_y + 1'b1) : in_y;
    abs_nxt[2*CW +: CW] = in_z[CW-1] ? (~in_z + 1'b1) : in_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r.valid <= start & ~busy;
      s1_ctl_r.zero  <= (abs_nxt == '0);
      s1_ctl_r.neg   <= neg_nxt;
    end
    s1_abs_r <= abs_nxt;
  end

  // ---- Stage 2: squares (one multiplier per lane) ----
  vn_ctl_t          s2_ctl_r;
  logic [3*CW-1:0]  s2_abs_r;
  logic [2*CW-1:0]  s2_sq_r [NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else begin
      s2_ctl_r <= s1_ctl_r;
    end
    s2_abs_r <= s1_abs_r;
    for (int l = 0; l < NUM_LANES; l++) begin
      s2_sq_r[l] <= s1_abs_r[l*CW +: CW] * s1_abs_r[l*CW +: CW];
    end
  end

  // ---- Stage 3: sum of squares; fits 2*CW bits (at most 3 * 2^(2CW-2)) ----
  vn_ctl_t          s3_ctl_r;
  logic [3*CW-1:0]  s3_abs_r;
  logic [2*CW-1:0]  s3_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else begin
      s3_ctl_r <= s2_ctl_r;
    end
    s3_abs_r <= s2_abs_r;
    s3_sum_r <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
  end

  // ---- Square root: CW cells, two radicand bits per cell ----
  vn_ctl_t          sq_ctl  [CW+1];
  logic [2*CW-1:0]  sq_rad  [CW+1];
  logic [CW+1:0]    sq_rem  [CW+1];
  logic [CW-1:0]    sq_root [CW+1];
  logic [3*CW-1:0]  sq_abs  [CW+1];

  assign sq_ctl[0]  = s3_ctl_r;
  assign sq_rad[0]  = s3_sum_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_abs[0]  = s3_abs_r;

  for (genvar i = 0; i < CW; i++) begin : g_sqrt
    vn_sqrt_cell #(.CW(CW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (sq_ctl[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .abs_i  (sq_abs[i]),
      .ctl_o  (sq_ctl[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .abs_o  (sq_abs[i+1])
    );
  end

  // ---- Divide: QW cells, one quotient bit per cell per lane ----
  // Remainder starts at abs>>1 with abs[0] as the first shifted-in bit;
  // abs <= magnitude keeps it below the divisor, so QW bits suffice.
  vn_ctl_t          dv_ctl [QW+1];
  logic [CW-1:0]    dv_mag [QW+1];
  logic [3*CW-1:0]  dv_rem [QW+1];
  logic [3*QW-1:0]  dv_quo [QW+1];
  logic [2:0]       first_nb;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_dv_init
    assign dv_rem[0][l*CW +: CW] = {1'b0, sq_abs[CW][l*CW+1 +: CW-1]};
    assign first_nb[l]           = sq_abs[CW][l*CW];
  end

  assign dv_ctl[0] = sq_ctl[CW];
  assign dv_mag[0] = sq_root[CW];
  assign dv_quo[0] = '0;

  for (genvar j = 0; j < QW; j++) begin : g_div
    vn_div_cell #(.CW(CW), .QW(QW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (dv_ctl[j]),
      .mag_i (dv_mag[j]),
      .nb_i  ((j == 0) ? first_nb : 3'b000),
      .rem_i (dv_rem[j]),
      .quo_i (dv_quo[j]),
      .ctl_o (dv_ctl[j+1]),
      .mag_o (dv_mag[j+1]),
      .rem_o (dv_rem[j+1]),
      .quo_o (dv_quo[j+1])
    );
  end

  // ---- Output register: sign restore, zero-vector override ----
  logic          out_valid_r;
  logic [UW-1:0] unit_r   [NUM_LANES];
  logic [UW-1:0] unit_nxt [NUM_LANES];
  logic [CW-1:0] mag_r;
  logic          zero_r;
  vn_ctl_t       fin;

  assign fin = dv_ctl[QW];

  always_comb begin
    logic [UW-1:0] q_ext;
    for (int l = 0; l < NUM_LANES; l++) begin
      q_ext = {1'b0, dv_quo[QW][l*QW +: QW]};
      if (fin.zero) begin
        unit_nxt[l] = '0;
      end else if (fin.neg[l]) begin
        unit_nxt[l] = ~q_ext + 1'b1;
      end else begin
        unit_nxt[l] = q_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin.valid;
    end
    zero_r <= fin.zero;
    mag_r  <= fin.zero ? '0 : dv_mag[QW];
    for (int l = 0; l < NUM_LANES; l++) begin
      unit_r[l] <= unit_nxt[l];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_unit_x      = unit_r[0];
  assign out_unit_y      = unit_r[1];
  assign out_unit_z      = unit_r[2];
  assign out_magnitude   = mag_r;
  assign out_zero_vector = zero_r;

  // ---- Assertions ----
  // Zero flag and zero magnitude go together on every result.
  a_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_magnitude == '0) == out_zero_vector))
    else $error("zero flag and magnitude disagree");

  // A zero vector carries all-zero unit components.
  a_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_vector) |->
      (out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0))
    else $error("zero vector with nonzero unit word");

  // Every accepted word comes out on out_valid after passing through the whole pipeline.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(start, LAT) && $past(rst_n, LAT)) |-> out_valid)
    else $error("result missing at pipeline latency");
endmodule

// ===== tb/vector3_normalize_checker.sv =====
// vector3_normalize_checker: watches the vector and result channels of the
// normalize block, predicts each unit vector and compares it. No package needed.
module vector3_normalize_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic signed [15:0] in_z,
  input  logic               out_valid,
  input  logic signed [15:0] out_unit_x,
  input  logic signed [15:0] out_unit_y,
  input  logic signed [15:0] out_unit_z,
  input  logic [15:0]        out_magnitude,
  input  logic               out_zero_vector,
  output int                 mismatches,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] ux;
    logic [15:0] uy;
    logic [15:0] uz;
    logic [15:0] mag;
    logic        zero;
  } unit_word_t;

  unit_word_t expected_units[$];

  function automatic logic [31:0] isqrt32(input logic [33:0] v);
    logic [33:0] root;
    logic [33:0] rem;
    logic [33:0] trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (34'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    rem = root;
    return rem[31:0];
  endfunction

  function automatic logic [15:0] scaled_div(input logic signed [15:0] c,
                                             input logic [31:0] mag);
    logic [31:0] a;
    logic [31:0] q;
    a = (c < 0) ? -32'(c) : 32'(c);
    q = (a << 14) / mag;
    return (c < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic unit_word_t normalize(input logic signed [15:0] x,
                                           input logic signed [15:0] y,
                                           input logic signed [15:0] z);
    unit_word_t w;
    logic [33:0] sum;
    logic [31:0] mag;
    sum = 34'(x) * 34'(x) + 34'(y) * 34'(y) + 34'(z) * 34'(z);
    w = '0;
    if (sum == 0) begin
      w.zero = 1'b1;
    end else begin
      mag = isqrt32(sum);
      w.ux = scaled_div(x, mag);
      w.uy = scaled_div(y, mag);
      w.uz = scaled_div(z, mag);
      w.mag = mag[15:0];
    end
    return w;
  endfunction

  initial mismatches = 0;

  always @(posedge clk) begin
    unit_word_t exp_w;
    unit_word_t got_w;
    if (rst_n) begin
      if (start && !busy) expected_units.push_back(normalize(in_x, in_y, in_z));
      if (out_valid) begin
        got_w = {out_unit_x, out_unit_y, out_unit_z, out_magnitude, out_zero_vector};
        if (expected_units.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", got_w);
        end else begin
          exp_w = expected_units.pop_front();
          if (exp_w !== got_w) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"word mismatch: exp x=%0d y=%0d z=%0d mag=%0d zero=%0b,",
                        " got x=%0d y=%0d z=%0d mag=%0d zero=%0b"},
                $signed(exp_w.ux), $signed(exp_w.uy), $signed(exp_w.uz), exp_w.mag,
                exp_w.zero, $signed(got_w.ux), $signed(got_w.uy), $signed(got_w.uz),
                got_w.mag, got_w.zero);
          end
        end
      end
    end
    pending = expected_units.size();
  end
endmodule

// ===== tb/vector3_normalize_test.sv =====
// vector3_normalize_test: stimulus and verdict for the vector normalize block.
// Depends on vector3_normalize and vector3_normalize_checker.
module vector3_normalize_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_x = '0;
  logic signed [15:0] in_y = '0;
  logic signed [15:0] in_z = '0;
  logic               out_valid;
  logic signed [15:0] out_unit_x, out_unit_y, out_unit_z;
  logic [15:0]        out_magnitude;
  logic               out_zero_vector;
  int                 mismatches;
  int                 pending;

  always #5 clk = ~clk;

  vector3_normalize u_dut (.*);
  vector3_normalize_checker u_chk (.*);

  // Present one vector, hold until accepted, then idle a random gap.
  // Back-to-back words keep start high across steps.
  task automatic send_vector(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
    int gap;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 7) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Random component: mix of full range, extremes and small magnitudes.
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 16)) - 8);
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int wait_cycles;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Directed: zero vector, extremes, single axes, tiny values.
    send_vector(16'h0000, 16'h0000, 16'h0000);
    send_vector(16'h8000, 16'h8000, 16'h8000);
    send_vector(16'h7fff, 16'h7fff, 16'h7fff);
    send_vector(16'h8000, 16'h0000, 16'h0000);
    send_vector(16'h0000, 16'h7fff, 16'h0000);
    send_vector(16'h0000, 16'h0000, 16'h8000);
    send_vector(16'h0001, 16'h0000, 16'h0000);
    send_vector(16'hffff, 16'h0000, 16'h0000);
    send_vector(16'h0001, 16'h0001, 16'h0001);
    send_vector(16'hffff, 16'hffff, 16'hffff);
    send_vector(16'h8000, 16'h7fff, 16'h0001);
    send_vector(16'h0100, 16'h0100, 16'hff00);
    send_vector(16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < 1800; i++) send_vector(rand_comp(), rand_comp(), rand_comp());
    start <= 1'b0;
    // Drain the pipe: wait for outstanding words, then a latency's worth more.
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
